>>> hw/rtl/fcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcw_pkg;

	localparam int unsigned COUNT_W = 13;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

	localparam logic [15:0] ENT_FREE     = 16'h0000;
	localparam logic [15:0] ENT_RESERVED = 16'h0001;
	localparam logic [15:0] ENT_BAD      = 16'hFFF7;
	localparam logic [15:0] ENT_EOC_MIN  = 16'hFFF8;
	localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;

	// register index, taken from paddr[2]
	localparam logic REG_FAT_ENTRY_COUNT = 1'b0;

	typedef enum logic [0:0] {
		REQ_LOAD = 1'b0,
		REQ_WALK = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_START = 3'd1,
		STAT_BAD_ENTRY = 3'd2,
		STAT_RANGE     = 3'd3,
		STAT_TOO_LONG  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_EMIT,
		S_ERROR
	} state_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [11:0] entry_index;
		logic [15:0] entry_value;
		logic [15:0] start_cluster;
	} req_t;

	typedef struct packed {
		logic [15:0] cluster;
		logic        is_last;
		status_t     status;
	} rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/fcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/fat16_cluster_chain_walker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// FAT16 cluster chain walker. Load items write one 16-bit entry of the allocation
// table; the table is not cleared by reset, so every entry a walk can reach must be
// loaded first. A walk item is checked against fat_entry_count, then the chain is
// followed once to check every link and once more to emit it, one table read per
// link in each pass; a stalled result side holds the emit pass. A failed walk yields
// one result with cluster 0, is_last set and the error status, as soon as the start
// check or the check pass fails and the output register is free. The single table
// read port sets the pace; new items are taken only between walks, while the last
// result may still wait in the output register.
module fat16_cluster_chain_walker_unit #(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned MAX_CHAIN   = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire fcw_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output fcw_pkg::rsp_t      rsp,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	import fcw_pkg::*;

	localparam int unsigned AW  = $clog2(TABLE_DEPTH);
	localparam int unsigned CW  = 17;
	localparam int unsigned LW  = 7;

	state_t              state_q, state_d;
	logic [COUNT_W-1:0]  count_q;
	logic [CW-1:0]       count_eff;
	logic [15:0]         cur_q, cur_d;
	logic [LW-1:0]       len_q, len_d;
	status_t             err_q, err_d;
	logic                rsp_valid_q;
	rsp_t                rsp_q, rsp_d;
	logic                rsp_load;
	logic                slot_free;
	logic                req_fire;
	logic                tbl_we;
	logic                tbl_re;
	logic [AW-1:0]       tbl_raddr;
	logic [15:0]         tbl_rdata;
	logic                ent_bad, ent_eoc, ent_range, chain_full;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FAT_ENTRY_COUNT) ? {19'd0, count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == REG_FAT_ENTRY_COUNT) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// clamp the count to the table size
	assign count_eff = (CW'(count_q) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;

	assign tbl_we = req_fire && req.req_type == REQ_LOAD &&
		CW'(req.entry_index) < CW'(TABLE_DEPTH);

	fcw_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(AW'(req.entry_index)),
		.wdata(req.entry_value),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	assign ent_bad    = tbl_rdata == ENT_FREE || tbl_rdata == ENT_RESERVED ||
		tbl_rdata == ENT_BAD;
	assign ent_eoc    = tbl_rdata >= ENT_EOC_MIN;
	assign ent_range  = CW'(tbl_rdata) >= count_eff;
	assign chain_full = len_q >= LW'(MAX_CHAIN);

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		len_d     = len_q;
		err_d     = err_q;
		tbl_re    = 1'b0;
		tbl_raddr = AW'(cur_q);
		rsp_load  = 1'b0;
		rsp_d     = rsp_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire && req.req_type == REQ_WALK) begin
					cur_d = req.start_cluster;
					len_d = LW'(1);
					if (req.start_cluster < FIRST_DATA_CLUSTER) begin
						err_d   = STAT_BAD_START;
						state_d = S_ERROR;
					end else if (CW'(req.start_cluster) >= count_eff) begin
						err_d   = STAT_RANGE;
						state_d = S_ERROR;
					end else begin
						tbl_re    = 1'b1;
						tbl_raddr = AW'(req.start_cluster);
						state_d   = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				// cur_q keeps the start cluster for the emit pass
				if (ent_bad) begin
					err_d   = STAT_BAD_ENTRY;
					state_d = S_ERROR;
				end else if (ent_eoc) begin
					tbl_re    = 1'b1;
					tbl_raddr = AW'(cur_q);
					state_d   = S_EMIT;
				end else if (ent_range) begin
					err_d   = STAT_RANGE;
					state_d = S_ERROR;
				end else if (chain_full) begin
					err_d   = STAT_TOO_LONG;
					state_d = S_ERROR;
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = AW'(tbl_rdata);
					len_d     = len_q + LW'(1);
				end
			end
			S_EMIT: begin
				// hold the read data until the output register frees up
				if (slot_free) begin
					rsp_load      = 1'b1;
					rsp_d.cluster = cur_q;
					rsp_d.is_last = ent_eoc;
					rsp_d.status  = STAT_OK;
					if (ent_eoc) begin
						state_d = S_IDLE;
					end else begin
						cur_d     = tbl_rdata;
						tbl_re    = 1'b1;
						tbl_raddr = AW'(tbl_rdata);
					end
				end
			end
			S_ERROR: begin
				if (slot_free) begin
					rsp_load      = 1'b1;
					rsp_d.cluster = 16'd0;
					rsp_d.is_last = 1'b1;
					rsp_d.status  = err_q;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		len_q <= len_d;
		err_q <= err_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> hw/rtl/fcw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fcw_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire fcw_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire fcw_pkg::rsp_t rsp
);

	import fcw_pkg::*;

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	else $error("result item changed while stalled");

	// an error result is a lone, last item with cluster zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_OK |-> rsp.is_last && rsp.cluster == 16'd0)
	else $error("error result malformed");

	// chain results never name a reserved cluster
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_OK |-> rsp.cluster >= FIRST_DATA_CLUSTER)
	else $error("chain result below first data cluster");

	// a walk item blocks the input side on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_WALK |=> !req_ready)
	else $error("input taken during a walk");

endmodule

bind fat16_cluster_chain_walker_unit fcw_checker u_fcw_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import fcw_pkg::*;

	localparam int unsigned TABLE_DEPTH = 4096;
	localparam int unsigned MAX_CHAIN   = 64;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 16;

	class chain_scoreboard;
		logic [15:0] fat [TABLE_DEPTH];
		bit          loaded [TABLE_DEPTH];
		int unsigned entry_count;
		rsp_t        expected_q[$];
		int unsigned errors;

		function new();
			entry_count = COUNT_RESET;
			errors = 0;
		endfunction

		function void report(string what);
			if (errors < 40)
				$display("mismatch: %s", what);
			errors++;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function int unsigned effective_count();
			return (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
		endfunction

		function rsp_t fault(status_t s);
			return rsp_t'{cluster: 16'd0, is_last: 1'b1, status: s};
		endfunction

		// Follow a chain the way the block does; returns 0 if it would read an
		// entry that was never loaded.
		function bit trace_chain(input logic [15:0] start, output rsp_t seq[$]);
			int unsigned n;
			int unsigned cur;
			logic [15:0] nxt;
			logic [15:0] path[$];
			seq = {};
			n = effective_count();
			if (start < FIRST_DATA_CLUSTER) begin
				seq.push_back(fault(STAT_BAD_START));
				return 1'b1;
			end
			if (start >= n) begin
				seq.push_back(fault(STAT_RANGE));
				return 1'b1;
			end
			cur = start;
			path.push_back(start);
			while (1'b1) begin
				if (!loaded[cur])
					return 1'b0;
				nxt = fat[cur];
				if (nxt == ENT_FREE || nxt == ENT_RESERVED || nxt == ENT_BAD) begin
					seq.push_back(fault(STAT_BAD_ENTRY));
					return 1'b1;
				end
				if (nxt >= ENT_EOC_MIN)
					break;
				// range check comes before the next table read
				if (nxt >= n) begin
					seq.push_back(fault(STAT_RANGE));
					return 1'b1;
				end
				if (path.size() >= MAX_CHAIN) begin
					seq.push_back(fault(STAT_TOO_LONG));
					return 1'b1;
				end
				cur = nxt;
				path.push_back(nxt);
			end
			foreach (path[k])
				seq.push_back(rsp_t'{cluster: path[k], is_last: (k == path.size() - 1),
					status: STAT_OK});
			return 1'b1;
		endfunction

		function void note_request(req_t item);
			rsp_t seq[$];
			if (item.req_type == REQ_LOAD) begin
				fat[item.entry_index] = item.entry_value;
				loaded[item.entry_index] = 1'b1;
				return;
			end
			if (!trace_chain(item.start_cluster, seq))
				report($sformatf("walk from %0d reaches an unloaded entry", item.start_cluster));
			foreach (seq[k])
				expected_q.push_back(seq[k]);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result cluster %0d last %0d status %0d",
					got.cluster, got.is_last, got.status));
				return;
			end
			want = expected_q.pop_front();
			if (got.cluster !== want.cluster)
				report($sformatf("cluster %0d, want %0d", got.cluster, want.cluster));
			if (got.is_last !== want.is_last)
				report($sformatf("is_last %0d, want %0d on cluster %0d",
					got.is_last, want.is_last, want.cluster));
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d on cluster %0d",
					got.status, want.status, want.cluster));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req_bus = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp_bus;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	chain_scoreboard sb = new();
	bit          req_calm = 1'b0;
	bit          rsp_calm = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;

	fat16_cluster_chain_walker_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_CHAIN(MAX_CHAIN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req_bus),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// switch between stretches of random gaps and stretches with none
	function automatic int unsigned draw_gap(inout bit calm);
		if ($urandom_range(15, 0) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(7, 0);
	endfunction

	initial begin
		int unsigned gap;
		forever begin
			gap = draw_gap(rsp_calm);
			@(negedge clk);
			if (gap != 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			sb.check_response(rsp_bus);
		end
	end

	task automatic send_item(input req_t item);
		int unsigned gap;
		gap = draw_gap(req_calm);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_bus <= item;
		do @(posedge clk); while (req_ready !== 1'b1);
		sb.note_request(item);
		items_sent++;
	endtask

	task automatic send_load(input logic [11:0] idx, input logic [15:0] value);
		req_t item;
		item.req_type = REQ_LOAD;
		item.entry_index = idx;
		item.entry_value = value;
		item.start_cluster = 16'($urandom_range(65535, 0));
		send_item(item);
	endtask

	task automatic send_walk(input logic [15:0] start);
		req_t item;
		rsp_t scratch[$];
		// never walk into an entry that was never loaded
		if (!sb.trace_chain(start, scratch))
			start = 16'($urandom_range(1, 0));
		item.req_type = REQ_WALK;
		item.entry_index = 12'($urandom_range(4095, 0));
		item.entry_value = 16'($urandom_range(65535, 0));
		item.start_cluster = start;
		send_item(item);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [12:0] value);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_FAT_ENTRY_COUNT, 2'b00};
		pwdata <= {19'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.entry_count = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Build a chain of distinct clusters with a random ending, load it, walk it.
	task automatic run_chain();
		int unsigned n_eff;
		int unsigned len;
		int unsigned pick;
		bit          dup;
		logic [15:0] nodes[$];
		logic [15:0] cand;
		logic [15:0] term;
		logic [15:0] start;
		n_eff = sb.effective_count();
		if (n_eff < 3) begin
			start = $urandom_range(1, 0) ? 16'($urandom_range(3, 0)) :
				16'($urandom_range(65535, 0));
			send_walk(start);
			return;
		end
		pick = $urandom_range(99, 0);
		if (pick < 80)
			len = $urandom_range(8, 1);
		else if (pick < 90)
			len = $urandom_range(40, 9);
		else if (pick < 95)
			len = MAX_CHAIN;
		else
			len = MAX_CHAIN + 1;
		if (len > n_eff - 2)
			len = n_eff - 2;
		while (nodes.size() < len) begin
			cand = 16'($urandom_range(n_eff - 1, 2));
			dup = 1'b0;
			foreach (nodes[k])
				if (nodes[k] == cand)
					dup = 1'b1;
			if (!dup)
				nodes.push_back(cand);
		end
		pick = $urandom_range(9, 0);
		if (pick < 6)
			term = ENT_EOC_MIN + 16'($urandom_range(7, 0));
		else if (pick == 6) begin
			case ($urandom_range(2, 0))
				0: term = ENT_FREE;
				1: term = ENT_RESERVED;
				default: term = ENT_BAD;
			endcase
		end else if (pick == 7)
			term = 16'($urandom_range(16'hFFF6, n_eff));
		else
			term = nodes[$urandom_range(len - 1, 0)];
		for (int k = 0; k < len; k++) begin
			send_load(12'(nodes[k]), (k + 1 < len) ? nodes[k + 1] : term);
			if ($urandom_range(9, 0) == 0)
				send_load(12'($urandom_range(4095, 0)), 16'($urandom_range(65535, 0)));
		end
		pick = $urandom_range(9, 0);
		if (pick == 0)
			start = 16'($urandom_range(65535, 0));
		else if (pick == 1)
			start = nodes[$urandom_range(len - 1, 0)];
		else
			start = nodes[0];
		send_walk(start);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// bad starts and starts past the table
		send_walk(16'd0);
		send_walk(16'd1);
		send_walk(16'hFFFF);
		send_walk(16'd4096);
		// single-cluster chains at both ends of the table, then a two-cluster chain
		send_load(12'd2, 16'hFFFF);
		send_walk(16'd2);
		send_load(12'd4095, ENT_EOC_MIN);
		send_walk(16'd4095);
		send_load(12'd3, 16'd4);
		send_load(12'd4, 16'hFFFC);
		send_walk(16'd3);
		// free, reserved and bad entries
		send_load(12'd5, ENT_FREE);
		send_walk(16'd5);
		send_load(12'd6, ENT_RESERVED);
		send_walk(16'd6);
		send_load(12'd7, ENT_BAD);
		send_walk(16'd7);
		// links past the entry count
		send_load(12'd8, 16'd4096);
		send_walk(16'd8);
		send_load(12'd9, 16'hFFF6);
		send_walk(16'd9);
		// self loop runs past the chain limit
		send_load(12'd10, 16'd10);
		send_walk(16'd10);
		send_load(12'd0, 16'hABCD);

		// count above the table depth clamps to the depth
		write_count(13'd8191);
		while (items_sent < 124)
			run_chain();
		write_count(13'd2);
		repeat (5) run_chain();
		write_count(13'd0);
		repeat (4) run_chain();
		write_count(13'd1);
		repeat (4) run_chain();
		write_count(13'($urandom_range(80, 3)));
		while (items_sent < 170)
			run_chain();
		// hold off until the block has drained, then go on
		wait_drained();
		while (items_sent < 190)
			run_chain();
		write_count(13'd4096);
		while (items_sent < 210)
			run_chain();

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
